>>> rtl/core/gmi_pkg.sv
// gmi_pkg: shared constants, codes and control structs of the genotype mode imputer
// used by the channel interfaces and by every module in rtl/core
`default_nettype none

package gmi_pkg;

   // capacity of the sample buffer
   localparam int MAX_SAMPLES_DEFAULT = 64;

   // field widths
   localparam int CODE_W = 8;
   localparam int GENO_W = 2;

   // genotype codes as kept in the sample buffer
   localparam logic [GENO_W-1:0] GENO_ZERO    = 2'd0;
   localparam logic [GENO_W-1:0] GENO_ONE     = 2'd1;
   localparam logic [GENO_W-1:0] GENO_TWO     = 2'd2;
   localparam logic [GENO_W-1:0] GENO_MISSING = 2'd3;

   // controller to datapath commands
   typedef struct packed {
      logic accept;   // input transfer this cycle
      logic decide;   // latch the major genotype
      logic drain;    // walk the buffer out
      logic clear;    // marker finished, clear counts
   } gmi_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic drain_done;   // nothing left to read, output register empty or its last result leaves this cycle
   } gmi_status_type;

endpackage

`default_nettype wire

>>> rtl/core/gmi_req_if.sv
// gmi_req_if: valid/ready channel carrying one raw sample code per transfer
// depends on gmi_pkg for field widths
`default_nettype none

interface gmi_req_if;
   logic                         valid;
   logic                         ready;
   logic [gmi_pkg::CODE_W-1:0]   genotype_code;
   logic                         last_sample;

   modport source (output valid, output genotype_code, output last_sample, input ready);
   modport sink   (input valid, input genotype_code, input last_sample, output ready);
endinterface

`default_nettype wire

>>> rtl/core/gmi_rsp_if.sv
// gmi_rsp_if: valid/ready channel carrying one imputed sample per transfer
// depends on gmi_pkg for field widths
`default_nettype none

interface gmi_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [gmi_pkg::GENO_W-1:0]   genotype;
   logic                         was_imputed;
   logic [gmi_pkg::GENO_W-1:0]   major_genotype;
   logic                         truncated;
   logic                         last_result;

   modport source (output valid, output genotype, output was_imputed, output major_genotype,
                   output truncated, output last_result, input ready);
   modport sink   (input valid, input genotype, input was_imputed, input major_genotype,
                   input truncated, input last_result, output ready);
endinterface

`default_nettype wire

>>> rtl/core/gmi_ctrl.sv
// gmi_ctrl: state machine sequencing load, decide and drain phases of a marker
// depends on gmi_pkg for the command and status structs
`default_nettype none

module gmi_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic                    req_last,
   output logic                         req_ready,
   output gmi_pkg::gmi_cmd_type         cmd,
   input  wire gmi_pkg::gmi_status_type status
);

   localparam logic [1:0] ST_LOAD   = 2'd0;
   localparam logic [1:0] ST_DECIDE = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign req_ready = (state_ff == ST_LOAD);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (accept && req_last) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (status.drain_done) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_comb begin
      cmd.accept = accept;
      cmd.decide = (state_ff == ST_DECIDE);
      cmd.drain  = (state_ff == ST_DRAIN);
      cmd.clear  = (state_ff == ST_DRAIN) && status.drain_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/gmi_datapath.sv
// gmi_datapath: sample buffer, genotype counters, major pick and readout pipeline
// depends on gmi_pkg for codes and the command and status structs
`default_nettype none

module gmi_datapath #(
   parameter int MAX_SAMPLES = gmi_pkg::MAX_SAMPLES_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire gmi_pkg::gmi_cmd_type         cmd,
   output gmi_pkg::gmi_status_type           status,
   input  wire logic [gmi_pkg::CODE_W-1:0]   genotype_code,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [gmi_pkg::GENO_W-1:0]        rsp_genotype,
   output logic                              rsp_was_imputed,
   output logic [gmi_pkg::GENO_W-1:0]        rsp_major_genotype,
   output logic                              rsp_truncated,
   output logic                              rsp_last_result
);

   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int IDX_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_SAMPLES);

   // sample buffer
   logic [gmi_pkg::GENO_W-1:0] store_mem [MAX_SAMPLES];

   // marker counters
   logic [CNT_W-1:0] count_zero_ff, count_zero_in;
   logic [CNT_W-1:0] count_one_ff,  count_one_in;
   logic [CNT_W-1:0] count_two_ff,  count_two_in;
   logic [CNT_W-1:0] stored_ff,     stored_in;
   logic             overflow_ff,   overflow_in;
   logic [gmi_pkg::GENO_W-1:0] major_ff, major_in;

   // readout
   logic [CNT_W-1:0]           rd_ptr_ff, rd_ptr_in;
   logic                       s1_valid_ff, s1_valid_in;
   logic [gmi_pkg::GENO_W-1:0] s1_geno_ff;
   logic                       s1_last_ff;
   logic                       o_valid_ff, o_valid_in;
   logic [gmi_pkg::GENO_W-1:0] o_geno_ff;
   logic                       o_imputed_ff;
   logic                       o_last_ff;

   logic                       has_room;
   logic                       wr_en;
   logic [gmi_pkg::GENO_W-1:0] code_norm;
   logic                       s1_move;
   logic                       rd_en;
   logic [CNT_W-1:0]           rd_ptr_next;
   logic                       s1_missing;

   assign has_room = (stored_ff < CAP);
   assign wr_en    = cmd.accept && has_room;

   always_comb begin
      priority if (genotype_code == gmi_pkg::CODE_W'(gmi_pkg::GENO_ZERO)) begin
         code_norm = gmi_pkg::GENO_ZERO;
      end else if (genotype_code == gmi_pkg::CODE_W'(gmi_pkg::GENO_ONE)) begin
         code_norm = gmi_pkg::GENO_ONE;
      end else if (genotype_code == gmi_pkg::CODE_W'(gmi_pkg::GENO_TWO)) begin
         code_norm = gmi_pkg::GENO_TWO;
      end else begin
         code_norm = gmi_pkg::GENO_MISSING;
      end
   end

   // counters and overflow
   always_comb begin
      count_zero_in = count_zero_ff;
      count_one_in  = count_one_ff;
      count_two_in  = count_two_ff;
      stored_in     = stored_ff;
      overflow_in   = overflow_ff;
      if (cmd.clear) begin
         count_zero_in = '0;
         count_one_in  = '0;
         count_two_in  = '0;
         stored_in     = '0;
         overflow_in   = 1'b0;
      end else if (cmd.accept) begin
         if (has_room) begin
            stored_in = stored_ff + CNT_W'(1);
            if (code_norm == gmi_pkg::GENO_ZERO) begin
               count_zero_in = count_zero_ff + CNT_W'(1);
            end
            if (code_norm == gmi_pkg::GENO_ONE) begin
               count_one_in = count_one_ff + CNT_W'(1);
            end
            if (code_norm == gmi_pkg::GENO_TWO) begin
               count_two_in = count_two_ff + CNT_W'(1);
            end
         end else begin
            overflow_in = 1'b1;
         end
      end
   end

   // major genotype, 2 and 1 must beat 0 strictly, ties with 0 fall to 0, a tie of 2 and 1 falls to 1
   always_comb begin
      major_in = major_ff;
      if (cmd.decide) begin
         if (count_two_ff > count_one_ff) begin
            major_in = (count_two_ff > count_zero_ff) ? gmi_pkg::GENO_TWO : gmi_pkg::GENO_ZERO;
         end else begin
            major_in = (count_one_ff > count_zero_ff) ? gmi_pkg::GENO_ONE : gmi_pkg::GENO_ZERO;
         end
      end
   end

   // readout: buffer read stage then output register
   assign s1_move     = s1_valid_ff && (!o_valid_ff || rsp_ready);
   assign rd_en       = cmd.drain && (rd_ptr_ff != stored_ff) && (!s1_valid_ff || s1_move);
   assign rd_ptr_next = rd_ptr_ff + CNT_W'(1);
   assign s1_missing  = (s1_geno_ff == gmi_pkg::GENO_MISSING);

   always_comb begin
      if (cmd.clear) begin
         rd_ptr_in = '0;
      end else if (rd_en) begin
         rd_ptr_in = rd_ptr_next;
      end else begin
         rd_ptr_in = rd_ptr_ff;
      end
      if (rd_en) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (s1_move) begin
         o_valid_in = 1'b1;
      end else if (rsp_ready) begin
         o_valid_in = 1'b0;
      end else begin
         o_valid_in = o_valid_ff;
      end
   end

   assign status.drain_done = cmd.drain && (rd_ptr_ff == stored_ff) && !s1_valid_ff
                              && (!o_valid_ff || rsp_ready);

   // buffer write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[stored_ff[IDX_W-1:0]] <= code_norm;
      end
      if (rd_en) begin
         s1_geno_ff <= store_mem[rd_ptr_ff[IDX_W-1:0]];
         s1_last_ff <= (rd_ptr_next == stored_ff);
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      major_ff <= major_in;
      if (s1_move) begin
         o_geno_ff    <= s1_missing ? major_ff : s1_geno_ff;
         o_imputed_ff <= s1_missing;
         o_last_ff    <= s1_last_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_zero_ff <= '0;
         count_one_ff  <= '0;
         count_two_ff  <= '0;
         stored_ff     <= '0;
         overflow_ff   <= 1'b0;
         rd_ptr_ff     <= '0;
         s1_valid_ff   <= 1'b0;
         o_valid_ff    <= 1'b0;
      end else begin
         count_zero_ff <= count_zero_in;
         count_one_ff  <= count_one_in;
         count_two_ff  <= count_two_in;
         stored_ff     <= stored_in;
         overflow_ff   <= overflow_in;
         rd_ptr_ff     <= rd_ptr_in;
         s1_valid_ff   <= s1_valid_in;
         o_valid_ff    <= o_valid_in;
      end
   end

   assign rsp_valid          = o_valid_ff;
   assign rsp_genotype       = o_geno_ff;
   assign rsp_was_imputed    = o_imputed_ff;
   assign rsp_major_genotype = major_ff;
   assign rsp_truncated      = overflow_ff;
   assign rsp_last_result    = o_last_ff;

`ifndef NO_ASSERTIONS
   a_store_bound: assert property (@(posedge clock) disable iff (reset)
      stored_ff <= CAP)
      else $error("sample count beyond capacity");

   a_counts_bound: assert property (@(posedge clock) disable iff (reset)
      ({2'b00, count_zero_ff} + {2'b00, count_one_ff} + {2'b00, count_two_ff})
         <= {2'b00, stored_ff})
      else $error("genotype counts exceed buffered samples");

   a_rd_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      rd_ptr_ff <= stored_ff)
      else $error("read pointer past buffered samples");

   a_no_missing_out: assert property (@(posedge clock) disable iff (reset)
      o_valid_ff |-> (o_geno_ff != gmi_pkg::GENO_MISSING))
      else $error("missing code reached the result");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> (!o_valid_ff || (rsp_ready && o_last_ff)))
      else $error("marker cleared before its last result");
`endif

endmodule

`default_nettype wire

>>> rtl/core/genotype_mode_imputer_core.sv
// throughput: one sample per cycle while loading, one result per cycle while draining unless rsp_ready is low
// input stalls during the decide and drain phases
// reset: synchronous, active high, clears counters and control; buffer contents stay undefined
// depends on gmi_pkg, gmi_req_if, gmi_rsp_if, gmi_ctrl and gmi_datapath
`default_nettype none

module genotype_mode_imputer_core #(
   parameter int MAX_SAMPLES = gmi_pkg::MAX_SAMPLES_DEFAULT
) (
   input wire logic   clock,
   input wire logic   reset,
   gmi_req_if.sink    req_ch,
   gmi_rsp_if.source  rsp_ch
);

   // command and status between controller and datapath
   gmi_pkg::gmi_cmd_type    cmd;
   gmi_pkg::gmi_status_type status;

   // controller: load phase takes samples, decide phase picks the major genotype,
   // drain phase walks the buffer out and clears the marker on the last transfer
   gmi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_last  (req_ch.last_sample),
      .req_ready (req_ch.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // datapath: sample buffer (one write port, one registered read port),
   // per-genotype counters, major pick register and the result register
   gmi_datapath #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .genotype_code      (req_ch.genotype_code),
      .rsp_valid          (rsp_ch.valid),
      .rsp_ready          (rsp_ch.ready),
      .rsp_genotype       (rsp_ch.genotype),
      .rsp_was_imputed    (rsp_ch.was_imputed),
      .rsp_major_genotype (rsp_ch.major_genotype),
      .rsp_truncated      (rsp_ch.truncated),
      .rsp_last_result    (rsp_ch.last_result)
   );

endmodule

`default_nettype wire
